// ----- src/ed_pkg.sv -----
// ----------------------------------------------------------------------------
// ed_pkg
// Shared types and codes for the edit distance engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ed_pkg;

  // Input transaction kinds (carried in s_axis_tuser)
  localparam logic [1:0] ACT_SRC     = 2'd0;
  localparam logic [1:0] ACT_TGT     = 2'd1;
  localparam logic [1:0] ACT_COMPUTE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRC_RD,
    S_CELL,
    S_ROW_END,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

// ----- src/edit_distance.sv -----
// ----------------------------------------------------------------------------
// edit_distance
// Levenshtein distance between two character strings, built one character
// per transaction, using one DP row held in a synchronous memory.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                               notes
//  s_axis    in   tuser[1:0] action, tdata char_code    append or compute
//  m_axis    out  tdata[6:0] distance, tuser overflow   one per compute
//
//  Appends are accepted while idle. A compute with both strings non-empty holds
//  s_axis_tready low while it fetches the first source character, then sweeps
//  the DP row memory once per source character, one cell per cycle plus a
//  row-end step to retire the row, and then loads the result. With an empty
//  string it skips the sweep and only loads the result. The load stalls while
//  an earlier result still waits in the output register; after it, loading
//  for the next run continues while the result is not taken.
//  Reset clears lengths, flags and control; the character and row memories
//  need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module edit_distance #(
  parameter int MAX_LEN   = 64,
  parameter int CHAR_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] char_code
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [6:0] distance, [7] zero
  output logic [0:0]       m_axis_tuser    // [0] overflow
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  ed_pkg::state_t state, state_next;

  // Memories
  logic [CHAR_BITS-1:0] src_mem [0:MAX_LEN-1];
  logic [CHAR_BITS-1:0] tgt_mem [0:MAX_LEN-1];
  logic [LW-1:0]        dp_mem  [0:MAX_LEN-1];
  logic [CHAR_BITS-1:0] src_q;
  logic [CHAR_BITS-1:0] tgt_q;
  logic [LW-1:0]        dp_q;

  // Control / datapath registers
  logic [LW-1:0] src_len;
  logic [LW-1:0] tgt_len;
  logic          dropped;
  logic [LW-1:0] row;
  logic [LW-1:0] col_rd;
  logic [LW-1:0] col_wr;
  logic          pend;
  logic [LW-1:0] left;
  logic [LW-1:0] diag;
  logic [LW-1:0] last;
  logic          out_valid;
  logic [6:0]    out_dist;
  logic          out_ovf;

  // Control strobes
  logic accept;
  logic retire;
  logic load_out;

  // Combinational datapath
  logic [CHAR_BITS+15:0] ch_ext;
  logic [CHAR_BITS-1:0]  ch;
  logic [LW-1:0]         row_inc;
  logic [LW-1:0]         col_inc;
  logic [LW-1:0]         wr_inc;
  logic [AW-1:0]         src_raddr;
  logic [LW-1:0]         above;
  logic [LW:0]           up_c, left_c, diag_c, best;
  logic [LW-1:0]         cell_val;
  logic [LW+6:0]         last_ext;
  logic                  any_empty;
  logic [LW-1:0]         empty_dist;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign ch_ext   = {{CHAR_BITS{1'b0}}, s_axis_tdata};
  assign ch       = ch_ext[CHAR_BITS-1:0];
  assign row_inc  = row + 1'b1;
  assign col_inc  = col_rd + 1'b1;
  assign wr_inc   = col_wr + 1'b1;
  assign last_ext = {7'b0, last};

  assign any_empty  = (src_len == '0) || (tgt_len == '0);
  assign empty_dist = (src_len == '0) ? tgt_len : src_len;

  // Fetch the next row's source character while the current row retires
  assign src_raddr = (state == ed_pkg::S_ROW_END) ? row_inc[AW-1:0] : row[AW-1:0];

  // One DP cell: the first row is the identity row and is never stored
  always_comb begin
    above  = (row == '0) ? wr_inc : dp_q;
    up_c   = {1'b0, above} + 1'b1;
    left_c = {1'b0, left} + 1'b1;
    diag_c = {1'b0, diag} + {{LW{1'b0}}, (src_q != tgt_q)};
    best   = (up_c < left_c) ? up_c : left_c;
    best   = (diag_c < best) ? diag_c : best;
    cell_val = best[LW-1:0];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ed_pkg::S_IDLE: begin
        if (accept && (s_axis_tuser == ed_pkg::ACT_COMPUTE)) begin
          state_next = any_empty ? ed_pkg::S_FINISH : ed_pkg::S_SRC_RD;
        end
      end
      ed_pkg::S_SRC_RD: state_next = ed_pkg::S_CELL;
      ed_pkg::S_CELL: begin
        if (col_inc == tgt_len) state_next = ed_pkg::S_ROW_END;
      end
      ed_pkg::S_ROW_END: begin
        state_next = (row_inc == src_len) ? ed_pkg::S_FINISH : ed_pkg::S_CELL;
      end
      ed_pkg::S_FINISH: begin
        if (!out_valid || m_axis_tready) state_next = ed_pkg::S_IDLE;
      end
      default: state_next = ed_pkg::S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    s_axis_tready = 1'b0;
    retire        = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      ed_pkg::S_IDLE:    s_axis_tready = 1'b1;
      ed_pkg::S_SRC_RD:  ;
      ed_pkg::S_CELL:    retire = pend;
      ed_pkg::S_ROW_END: retire = 1'b1;
      ed_pkg::S_FINISH:  load_out = !out_valid || m_axis_tready;
      default:           ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ed_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Character memories: append writes, sweep reads
  always_ff @(posedge clk) begin
    if (accept && (s_axis_tuser == ed_pkg::ACT_SRC) && (src_len < LW'(MAX_LEN))) begin
      src_mem[src_len[AW-1:0]] <= ch;
    end
    src_q <= src_mem[src_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && (s_axis_tuser == ed_pkg::ACT_TGT) && (tgt_len < LW'(MAX_LEN))) begin
      tgt_mem[tgt_len[AW-1:0]] <= ch;
    end
    tgt_q <= tgt_mem[col_rd[AW-1:0]];
  end

  // DP row memory: read column ahead, write back the retiring cell
  always_ff @(posedge clk) begin
    if (retire) begin
      dp_mem[col_wr[AW-1:0]] <= cell_val;
    end
    dp_q <= dp_mem[col_rd[AW-1:0]];
  end

  // Lengths and drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      src_len <= '0;
      tgt_len <= '0;
      dropped <= 1'b0;
    end else if (load_out) begin
      src_len <= '0;
      tgt_len <= '0;
      dropped <= 1'b0;
    end else if (accept) begin
      unique case (s_axis_tuser)
        ed_pkg::ACT_SRC: begin
          if (src_len < LW'(MAX_LEN)) src_len <= src_len + 1'b1;
          else dropped <= 1'b1;
        end
        ed_pkg::ACT_TGT: begin
          if (tgt_len < LW'(MAX_LEN)) tgt_len <= tgt_len + 1'b1;
          else dropped <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Sweep sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      unique case (state)
        ed_pkg::S_IDLE: begin
          pend   <= 1'b0;
          row    <= '0;
          col_rd <= '0;
          if (accept && (s_axis_tuser == ed_pkg::ACT_COMPUTE)) last <= empty_dist;
        end
        ed_pkg::S_SRC_RD: begin
          left   <= LW'(1);
          diag   <= '0;
          col_rd <= '0;
          pend   <= 1'b0;
        end
        ed_pkg::S_CELL: begin
          pend   <= 1'b1;
          col_wr <= col_rd;
          col_rd <= col_inc;
          if (pend) begin
            left <= cell_val;
            diag <= above;
          end
        end
        ed_pkg::S_ROW_END: begin
          // Retire the last cell and seed the next row's boundary
          last   <= cell_val;
          pend   <= 1'b0;
          col_rd <= '0;
          row    <= row_inc;
          left   <= row_inc + 1'b1;
          diag   <= row_inc;
        end
        ed_pkg::S_FINISH: ;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      out_dist <= last_ext[6:0];
      out_ovf  <= dropped;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_dist};
  assign m_axis_tuser  = out_ovf;

  // Assertions
  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ed_pkg::S_CELL || state == ed_pkg::S_ROW_END) |-> (row < src_len))
    else $error("sweep row beyond source length");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ed_pkg::S_CELL) |-> (col_rd < tgt_len))
    else $error("column read beyond target length");

  a_row_end_retires: assert property (@(posedge clk) disable iff (rst)
    (state == ed_pkg::S_ROW_END) |-> (pend && (col_rd == tgt_len)))
    else $error("row end without a pending cell");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (src_len == '0 && tgt_len == '0 && !dropped && m_axis_tvalid))
    else $error("strings not cleared after result load");

  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (last <= LW'(MAX_LEN)))
    else $error("distance exceeds capacity");

endmodule

`default_nettype wire
